@@ hdl/hfm_pkg.sv @@
// ----------------------------------------------------------------------------
// hfm_pkg: shared types and constants of the heartbeat frame monitor
// Request and result layouts, status codes, acceptance limits and the
// CRC-16 byte step.
// ----------------------------------------------------------------------------
package hfm_pkg;

  localparam int TIME_W    = 48;
  localparam int HB_ID_W   = 11;
  localparam int TMO_W     = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic [15:0] CRC_POLY        = 16'h1021;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [7:0]  FLAG_BAD_MASK   = 8'hFE;
  localparam logic [7:0]  MAX_NODE_MODE   = 8'd5;
  localparam logic [6:0]  HB_LENGTH       = 7'd12;
  localparam logic [7:0]  SCHEMA_ONE      = 8'd1;
  localparam logic [3:0]  FORMAT_REQUIRED = 4'hC;
  localparam logic [TMO_W-1:0] TIMEOUT_RESET = 32'd500;

  typedef enum logic {
    OP_FRAME = 1'b0,
    OP_TIME  = 1'b1
  } hfm_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEARTBEAT_ID = 1'b0,
    CFG_TIMEOUT_MS   = 1'b1
  } hfm_cfg_idx_t;

  typedef enum logic [1:0] {
    ST_UNKNOWN = 2'd0,
    ST_ALIVE   = 2'd1,
    ST_TIMEOUT = 2'd2
  } hfm_status_t;

  typedef struct packed {
    logic              opcode;
    logic [TIME_W-1:0] now_ms;
    logic [28:0]       frame_id;
    logic [3:0]        frame_format;
    logic [6:0]        payload_len;
    logic [7:0]        schema_version;
    logic [7:0]        node_mode;
    logic [7:0]        sequence_number;
    logic [7:0]        node_flags;
    logic [31:0]       sender_uptime;
    logic [15:0]       fault_bits;
    logic [15:0]       crc_received;
  } hfm_in_t;

  typedef struct packed {
    logic              accepted;
    logic [1:0]        link_status;
    logic [2:0]        last_node_mode;
    logic [7:0]        last_sequence;
    logic              last_flags;
    logic [31:0]       last_uptime;
    logic [15:0]       last_fault_bits;
    logic [TIME_W-1:0] received_at_ms;
    logic [TIME_W-1:0] age_ms;
  } hfm_out_t;

  // Frame check verdicts, one per rule group.
  typedef struct packed {
    logic hdr_ok;
    logic crc_ok;
    logic seq_ok;
  } hfm_chk_t;

  // CRC-16, MSB first, no reflection: fold in one byte.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  byte_in);
    logic [15:0] c;
    c = crc_in ^ {byte_in, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ hdl/hfm_ifs.sv @@
// ----------------------------------------------------------------------------
// hfm_ifs: valid/ready channels of the heartbeat frame monitor
// Request, result and register write channels.
// ----------------------------------------------------------------------------
interface hfm_in_if import hfm_pkg::*; ();
  logic    valid;
  logic    ready;
  hfm_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hfm_out_if import hfm_pkg::*; ();
  logic     valid;
  logic     ready;
  hfm_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hfm_cfg_if import hfm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [TMO_W-1:0]     wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

@@ hdl/heartbeat_frame_monitor.sv @@
// ----------------------------------------------------------------------------
// heartbeat_frame_monitor: heartbeat watchdog for a CAN FD node
// Validates heartbeat frames, tracks the link status against a silence
// limit and reports the last heartbeat with its age for every request.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  in_ch    in   valid/ready   hfm_in_t  (frame or time update request)
//  out_ch   out  valid/ready   hfm_out_t (one result per request)
//  cfg_ch   in   valid/ready   index + wdata (heartbeat_id, timeout_ms)
//
//  One request per cycle sustained while out_ch.ready stays high; a request
//  passes the input register, then the result register, before its result leaves.
//  All checks, the CRC and the state update sit between those two registers.
//  Stalls on out_ch hold both registers; in_ch.ready drops only while both
//  registers hold requests and out_ch.ready is low.
//  Synchronous reset clears the stored heartbeat, status and the valid flags of
//  both registers to their defaults; cfg_ch is always ready.
// ----------------------------------------------------------------------------
module heartbeat_frame_monitor import hfm_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  hfm_in_if.sink        in_ch,
  hfm_out_if.source     out_ch,
  hfm_cfg_if.sink       cfg_ch
);

  // Configuration
  logic [HB_ID_W-1:0] hb_id_r;
  logic [TMO_W-1:0]   timeout_r;

  // Input stage
  logic    s1_valid_r;
  hfm_in_t s1_item_r;

  // Monitor state
  logic              seen_any_r, seen_any_nxt;
  logic [7:0]        seq_r, seq_nxt;
  hfm_status_t       status_r, status_nxt;
  logic [2:0]        node_mode_r, node_mode_nxt;
  logic              flags_r, flags_nxt;
  logic [31:0]       uptime_r, uptime_nxt;
  logic [15:0]       faults_r, faults_nxt;
  logic [TIME_W-1:0] time_r, time_nxt;

  // Result stage
  logic     out_valid_r;
  hfm_out_t out_r, out_nxt;

  logic              out_free;
  logic              s1_fire;
  logic              frame_acc;
  logic              timeout_hit;
  logic              now_ge;
  logic [TIME_W-1:0] diff;
  hfm_chk_t          chk;

  assign out_free     = !out_valid_r || out_ch.ready;
  assign s1_fire      = s1_valid_r && out_free;
  assign in_ch.ready  = !s1_valid_r || out_free;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hb_id_r   <= '0;
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_HEARTBEAT_ID: hb_id_r   <= cfg_ch.wdata[HB_ID_W-1:0];
        CFG_TIMEOUT_MS:   timeout_r <= cfg_ch.wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item_r <= in_ch.data;
    end
  end

  hfm_check u_check (
    .item     (s1_item_r),
    .hb_id    (hb_id_r),
    .seen_any (seen_any_r),
    .last_seq (seq_r),
    .status   (status_r),
    .chk      (chk)
  );

  assign frame_acc = (s1_item_r.opcode == OP_FRAME) &&
                     chk.hdr_ok && chk.crc_ok && chk.seq_ok;

  assign now_ge      = s1_item_r.now_ms >= time_r;
  assign diff        = s1_item_r.now_ms - time_r;
  assign timeout_hit = (s1_item_r.opcode == OP_TIME) && (status_r == ST_ALIVE) &&
                       now_ge && (diff >= TIME_W'(timeout_r));

  always_comb begin
    seen_any_nxt  = seen_any_r;
    seq_nxt       = seq_r;
    status_nxt    = status_r;
    node_mode_nxt = node_mode_r;
    flags_nxt     = flags_r;
    uptime_nxt    = uptime_r;
    faults_nxt    = faults_r;
    time_nxt      = time_r;
    if (frame_acc) begin
      seen_any_nxt  = 1'b1;
      seq_nxt       = s1_item_r.sequence_number;
      status_nxt    = ST_ALIVE;
      node_mode_nxt = s1_item_r.node_mode[2:0];
      flags_nxt     = s1_item_r.node_flags[0];
      uptime_nxt    = s1_item_r.sender_uptime;
      faults_nxt    = s1_item_r.fault_bits;
      time_nxt      = s1_item_r.now_ms;
    end else if (timeout_hit) begin
      status_nxt = ST_TIMEOUT;
    end
  end

  always_comb begin
    out_nxt.accepted        = frame_acc;
    out_nxt.link_status     = status_nxt;
    out_nxt.last_node_mode  = node_mode_nxt;
    out_nxt.last_sequence   = seq_nxt;
    out_nxt.last_flags      = flags_nxt;
    out_nxt.last_uptime     = uptime_nxt;
    out_nxt.last_fault_bits = faults_nxt;
    out_nxt.received_at_ms  = time_nxt;
    // A fresh heartbeat is stamped with now, so its age is zero.
    if (!frame_acc && seen_any_r && now_ge) begin
      out_nxt.age_ms = diff;
    end else begin
      out_nxt.age_ms = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_any_r  <= 1'b0;
      seq_r       <= '0;
      status_r    <= ST_UNKNOWN;
      node_mode_r <= '0;
      flags_r     <= 1'b0;
      uptime_r    <= '0;
      faults_r    <= '0;
      time_r      <= '0;
    end else if (s1_fire) begin
      seen_any_r  <= seen_any_nxt;
      seq_r       <= seq_nxt;
      status_r    <= status_nxt;
      node_mode_r <= node_mode_nxt;
      flags_r     <= flags_nxt;
      uptime_r    <= uptime_nxt;
      faults_r    <= faults_nxt;
      time_r      <= time_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_r <= out_nxt;
    end
  end

`ifndef SYNTH
  a_acc_alive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.accepted |-> out_r.link_status == ST_ALIVE && out_r.age_ms == '0)
    else $error("accepted heartbeat not reported alive with zero age");

  a_unknown_until_seen: assert property (@(posedge clk) disable iff (!rst_n)
    !seen_any_r |-> status_r == ST_UNKNOWN && time_r == '0)
    else $error("status or time left reset value before any heartbeat");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_free |=> s1_valid_r && $stable(s1_item_r))
    else $error("stalled request dropped or changed in input stage");

  a_state_only_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_fire |=> $stable(status_r) && $stable(seq_r) && $stable(time_r))
    else $error("monitor state changed without a request in flight");
`endif

endmodule

@@ hdl/hfm_check.sv @@
// ----------------------------------------------------------------------------
// hfm_check: heartbeat frame validation
// Header and payload range checks, CRC-16 over identifier and payload,
// and the sequence advance rule against the stored heartbeat.
// ----------------------------------------------------------------------------
module hfm_check import hfm_pkg::*; (
  input  hfm_in_t            item,
  input  logic [HB_ID_W-1:0] hb_id,
  input  logic               seen_any,
  input  logic [7:0]         last_seq,
  input  hfm_status_t        status,
  output hfm_chk_t           chk
);

  logic [15:0] crc;
  logic [7:0]  delta;

  always_comb begin
    crc = CRC_INIT;
    crc = crc16_byte(crc, hb_id[7:0]);
    crc = crc16_byte(crc, {5'b0, hb_id[HB_ID_W-1:8]});
    crc = crc16_byte(crc, item.schema_version);
    crc = crc16_byte(crc, item.node_mode);
    crc = crc16_byte(crc, item.sequence_number);
    crc = crc16_byte(crc, item.node_flags);
    crc = crc16_byte(crc, item.sender_uptime[7:0]);
    crc = crc16_byte(crc, item.sender_uptime[15:8]);
    crc = crc16_byte(crc, item.sender_uptime[23:16]);
    crc = crc16_byte(crc, item.sender_uptime[31:24]);
    crc = crc16_byte(crc, item.fault_bits[7:0]);
    crc = crc16_byte(crc, item.fault_bits[15:8]);
  end

  assign delta = item.sequence_number - last_seq;

  always_comb begin
    chk.hdr_ok = (item.frame_id == 29'(hb_id)) &&
                 (item.frame_format == FORMAT_REQUIRED) &&
                 (item.payload_len == HB_LENGTH) &&
                 (item.schema_version == SCHEMA_ONE) &&
                 (item.node_mode <= MAX_NODE_MODE) &&
                 ((item.node_flags & FLAG_BAD_MASK) == 8'h00);
    chk.crc_ok = (crc == item.crc_received);
    // First frame takes any sequence; after a timeout any nonzero step.
    chk.seq_ok = !seen_any ||
                 ((delta != 8'd0) && ((status == ST_TIMEOUT) || !delta[7]));
  end

endmodule
